// ----- sv/fwc_pkg.sv -----
`default_nettype none

package fwc_pkg;

  // Default sizes
  localparam int CHANNELS_DEF = 16;
  localparam int MEMBERS_DEF  = 64;
  localparam int KINDS_DEF    = 14;

  // Opcodes
  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_CHAN  = 2'd1;
  localparam logic [1:0] OP_DFLT  = 2'd2;

  // Event kinds with fixed meaning
  localparam logic [3:0] KIND_JOIN  = 4'd0;
  localparam logic [3:0] KIND_CYCLE = 4'd3;
  localparam logic [3:0] KIND_LEAVE = 4'd4;

  // One (channel, kind) slot; negative period or limit selects the default
  typedef struct packed {
    logic [16:0] period;
    logic [16:0] limit;
    logic [16:0] count;
    logic [31:0] start;
  } slot_entry_t;

  localparam slot_entry_t SLOT_RESET = '{
    period: 17'h1FFFF,
    limit:  17'h1FFFF,
    count:  17'd0,
    start:  32'd0
  };

  // One result item
  typedef struct packed {
    logic [3:0]  kind;
    logic        flood;
    logic [15:0] limit;
    logic [15:0] period;
    logic [31:0] elapsed;
  } result_t;

  // Window update: result, write-back request and new slot contents
  typedef struct packed {
    result_t     res;
    logic        wr;
    slot_entry_t entry;
  } win_t;

endpackage

`default_nettype wire

// ----- sv/fwc_ram.sv -----
`default_nettype none

module fwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/fwc_window.sv -----
`default_nettype none

module fwc_window (
  input  wire fwc_pkg::slot_entry_t entry,
  input  wire logic [15:0]          dflt_period,
  input  wire logic [15:0]          dflt_limit,
  input  wire logic [3:0]           kind,
  input  wire logic [31:0]          now,
  output fwc_pkg::win_t             win
);

  logic [15:0] period;
  logic [15:0] limit;
  logic [31:0] diff;
  logic        restart;
  logic [16:0] cnt_inc;
  logic [16:0] cnt_new;
  logic        over;

  // Resolve effective period and limit
  assign period = entry.period[16] ? dflt_period : entry.period[15:0];
  assign limit  = entry.limit[16]  ? dflt_limit  : entry.limit[15:0];

  // Window age and restart test, modulo 2^32
  assign diff    = now - entry.start;
  assign restart = diff > {16'd0, period};

  // Count with restart folded in, then the flood test
  assign cnt_inc = entry.count + 17'd1;
  assign cnt_new = restart ? 17'd1 : cnt_inc;
  assign over    = cnt_new > {1'b0, limit};

  always_comb begin
    win = '0;
    win.res.kind = kind;
    win.entry    = entry;
    if (period != 16'd0) begin
      win.wr            = 1'b1;
      win.res.flood     = over;
      win.res.limit     = limit;
      win.res.period    = period;
      win.res.elapsed   = restart ? 32'd0 : diff;
      win.entry.count   = over ? 17'd0 : cnt_new;
      win.entry.start   = (restart || over) ? now : entry.start;
    end
  end

endmodule

`default_nettype wire

// ----- sv/flood_window_counter_unit.sv -----
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// cfg      | in        | cfg_we               | cfg_data (cycle_window)
// in       | in        | in_valid / in_ready  | opcode, channel, member, stat_kind,
//          |           |                      | now_seconds, period_value, limit_value
// out      | out       | out_valid / out_ready| kind_out, flood, limit_out, period_out,
//          |           |                      | elapsed, last
//
// An event reads its slot and join stamp, then computes and writes back; a leave that
// also reports a cycle adds a step, as the cycle slot is read through the same slot
// memory read port. A policy write reads the slot, then writes it back; default writes
// and dropped items finish when taken. After reset no item is accepted while a pass
// over max(CHANNELS*KINDS, CHANNELS*MEMBERS) addresses clears both memories.
// A result waiting in the output register stalls only the next compute step.

module flood_window_counter_unit #(
  parameter int CHANNELS = fwc_pkg::CHANNELS_DEF,
  parameter int MEMBERS  = fwc_pkg::MEMBERS_DEF,
  parameter int KINDS    = fwc_pkg::KINDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         opcode,
  input  wire logic [3:0]         channel,
  input  wire logic [5:0]         member,
  input  wire logic [3:0]         stat_kind,
  input  wire logic [31:0]        now_seconds,
  input  wire logic signed [16:0] period_value,
  input  wire logic signed [16:0] limit_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              kind_out,
  output logic                    flood,
  output logic [15:0]             limit_out,
  output logic [15:0]             period_out,
  output logic [31:0]             elapsed,
  output logic                    last
);

  localparam int SLOT_N  = CHANNELS * KINDS;
  localparam int JOIN_N  = CHANNELS * MEMBERS;
  localparam int CLR_N   = (SLOT_N > JOIN_N) ? SLOT_N : JOIN_N;
  localparam int SLOT_AW = (SLOT_N > 1) ? $clog2(SLOT_N) : 1;
  localparam int JOIN_AW = (JOIN_N > 1) ? $clog2(JOIN_N) : 1;
  localparam int CLR_W   = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam int KIND_AW = $clog2(KINDS);
  localparam int SLOT_W  = $bits(fwc_pkg::slot_entry_t);
  localparam logic CYCLE_ON = (int'(fwc_pkg::KIND_CYCLE) < KINDS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_POL   = 3'd2;
  localparam logic [2:0] ST_EVT   = 3'd3;
  localparam logic [2:0] ST_CYC   = 3'd4;

  logic [2:0]       state, state_next;
  logic [CLR_W-1:0] clr_cnt, clr_cnt_next;
  logic [15:0]      cycle_window;
  logic [15:0]      dflt_period [KINDS];
  logic [15:0]      dflt_limit  [KINDS];

  // Item registers
  logic [3:0]  ch_r;
  logic [5:0]  mem_r;
  logic [3:0]  kind_r;
  logic [31:0] now_r;
  logic [16:0] pv_r;
  logic [16:0] lv_r;

  logic accept, kind_ok, ch_ok, mem_ok, out_free, emit, last_next, dflt_we, cycle_hit;

  logic                slot_we, slot_re, join_we, join_re;
  logic [SLOT_AW-1:0]  slot_waddr, slot_raddr, slot_in, slot_evt, slot_cyc;
  logic [JOIN_AW-1:0]  join_waddr, join_in, join_evt;
  logic [SLOT_W-1:0]   slot_rdata_bits;
  fwc_pkg::slot_entry_t slot_rdata, slot_wdata, pol_entry;
  logic [31:0]         join_rdata, join_wdata;

  logic [3:0]          win_kind;
  logic [KIND_AW-1:0]  dflt_idx;
  fwc_pkg::win_t       win;

  // Handshake and range checks
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign kind_ok  = int'(stat_kind) < KINDS;
  assign ch_ok    = int'(channel) < CHANNELS;
  assign mem_ok   = int'(member) < MEMBERS;
  assign out_free = !out_valid || out_ready;

  // Memory addresses
  assign slot_in  = SLOT_AW'(int'(channel) * KINDS + int'(stat_kind));
  assign join_in  = JOIN_AW'(int'(channel) * MEMBERS + int'(member));
  assign slot_evt = SLOT_AW'(int'(ch_r) * KINDS + int'(kind_r));
  assign slot_cyc = SLOT_AW'(int'(ch_r) * KINDS + int'(fwc_pkg::KIND_CYCLE));
  assign join_evt = JOIN_AW'(int'(ch_r) * MEMBERS + int'(mem_r));

  assign slot_rdata = fwc_pkg::slot_entry_t'(slot_rdata_bits);

  // Channel policy write-back: a changed period clears the count
  always_comb begin
    pol_entry        = slot_rdata;
    pol_entry.period = pv_r;
    pol_entry.limit  = lv_r;
    if (pv_r != slot_rdata.period) begin
      pol_entry.count = 17'd0;
    end
  end

  // Window evaluation for the current kind
  assign win_kind = (state == ST_CYC) ? fwc_pkg::KIND_CYCLE : kind_r;
  assign dflt_idx = KIND_AW'(win_kind);

  fwc_window u_window (
    .entry       (slot_rdata),
    .dflt_period (dflt_period[dflt_idx]),
    .dflt_limit  (dflt_limit[dflt_idx]),
    .kind        (win_kind),
    .now         (now_r),
    .win         (win)
  );

  // Leave shortly after join reports a cycle
  assign cycle_hit = CYCLE_ON && (kind_r == fwc_pkg::KIND_LEAVE) &&
                     ((now_r - join_rdata) < {16'd0, cycle_window});

  // Sequencer
  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    slot_re      = 1'b0;
    slot_raddr   = slot_in;
    join_re      = 1'b0;
    slot_we      = 1'b0;
    slot_waddr   = slot_evt;
    slot_wdata   = win.entry;
    join_we      = 1'b0;
    join_waddr   = join_evt;
    join_wdata   = now_r;
    emit         = 1'b0;
    last_next    = 1'b1;
    dflt_we      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        slot_we    = int'(clr_cnt) < SLOT_N;
        slot_waddr = clr_cnt[SLOT_AW-1:0];
        slot_wdata = fwc_pkg::SLOT_RESET;
        join_we    = int'(clr_cnt) < JOIN_N;
        join_waddr = clr_cnt[JOIN_AW-1:0];
        join_wdata = 32'd0;
        if (int'(clr_cnt) == CLR_N - 1) begin
          state_next = ST_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + CLR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept && kind_ok) begin
          if (opcode == fwc_pkg::OP_DFLT) begin
            dflt_we = 1'b1;
          end else if (opcode == fwc_pkg::OP_CHAN && ch_ok) begin
            slot_re    = 1'b1;
            state_next = ST_POL;
          end else if (opcode == fwc_pkg::OP_EVENT && ch_ok && mem_ok) begin
            slot_re    = 1'b1;
            join_re    = 1'b1;
            state_next = ST_EVT;
          end
        end
      end
      ST_POL: begin
        slot_we    = 1'b1;
        slot_wdata = pol_entry;
        state_next = ST_IDLE;
      end
      ST_EVT: begin
        if (out_free) begin
          emit    = 1'b1;
          slot_we = win.wr;
          join_we = (kind_r == fwc_pkg::KIND_JOIN);
          if (cycle_hit) begin
            last_next  = 1'b0;
            slot_re    = 1'b1;
            slot_raddr = slot_cyc;
            state_next = ST_CYC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_CYC: begin
        if (out_free) begin
          emit       = 1'b1;
          slot_we    = win.wr;
          slot_waddr = slot_cyc;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  fwc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_N)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata_bits)
  );

  fwc_ram #(
    .WIDTH (32),
    .DEPTH (JOIN_N)
  ) u_join_ram (
    .clk   (clk),
    .we    (join_we),
    .waddr (join_waddr),
    .wdata (join_wdata),
    .re    (join_re),
    .raddr (join_in),
    .rdata (join_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  // Configuration register and per-kind defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_window <= 16'd0;
      for (int k = 0; k < KINDS; k++) begin
        dflt_period[k] <= 16'd0;
        dflt_limit[k]  <= 16'd0;
      end
    end else begin
      if (cfg_we) begin
        cycle_window <= cfg_data;
      end
      if (dflt_we) begin
        dflt_period[KIND_AW'(stat_kind)] <= period_value[16] ? 16'd0 : period_value[15:0];
        dflt_limit[KIND_AW'(stat_kind)]  <= limit_value[16]  ? 16'd0 : limit_value[15:0];
      end
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r   <= channel;
      mem_r  <= member;
      kind_r <= stat_kind;
      now_r  <= now_seconds;
      pv_r   <= period_value;
      lv_r   <= limit_value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_out   <= win.res.kind;
      flood      <= win.res.flood;
      limit_out  <= win.res.limit;
      period_out <= win.res.period;
      elapsed    <= win.res.elapsed;
      last       <= last_next;
    end
  end

  // Slot writes never collide with a new item's read
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !slot_we)
    else $error("slot write while idle");

  // A result loads only into a free output register
  assert property (@(posedge clk) disable iff (rst) emit |-> out_free)
    else $error("result overwrote a pending item");

  // A non-final result is always followed by the cycle step
  assert property (@(posedge clk) disable iff (rst) (emit && !last_next) |=> state == ST_CYC)
    else $error("missing cycle result");

endmodule

`default_nettype wire

// ----- bench/tb_flood_window_counter_unit.sv -----
`timescale 1ns / 100ps

module tb_flood_window_counter_unit;

  localparam int N_CHAN      = fwc_pkg::CHANNELS_DEF;
  localparam int N_MEMB      = fwc_pkg::MEMBERS_DEF;
  localparam int N_KIND      = fwc_pkg::KINDS_DEF;
  localparam int QUIET_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  channel;
    logic [5:0]  member;
    logic [3:0]  kind;
    logic [31:0] now;
    logic [16:0] period;
    logic [16:0] limit;
  } flood_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic        flood;
    logic [15:0] limit;
    logic [15:0] period;
    logic [31:0] elapsed;
    logic        last;
  } rate_verdict_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = '0;
  logic [3:0]         channel = '0;
  logic [5:0]         member = '0;
  logic [3:0]         stat_kind = '0;
  logic [31:0]        now_seconds = '0;
  logic signed [16:0] period_value = '0;
  logic signed [16:0] limit_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         kind_out;
  logic               flood;
  logic [15:0]        limit_out;
  logic [15:0]        period_out;
  logic [31:0]        elapsed;
  logic               last;

  // Predictor state
  logic signed [16:0] chan_period [N_CHAN*N_KIND];
  logic signed [16:0] chan_limit  [N_CHAN*N_KIND];
  logic [16:0]        win_count   [N_CHAN*N_KIND];
  logic [31:0]        win_start   [N_CHAN*N_KIND];
  logic [15:0]        dflt_period [N_KIND];
  logic [15:0]        dflt_limit  [N_KIND];
  logic [31:0]        join_stamp  [N_CHAN*N_MEMB];
  logic [15:0]        cycle_win = '0;

  flood_item_t   pend_items [$];
  rate_verdict_t verdict_q [$];
  flood_item_t   drv_item = '0;

  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_results = 0;
  int   n_fail = 0;
  int   quiet_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_left = 0;
  logic rx_hold_req = 1'b0;
  logic [31:0] time_cursor = 32'd1000;

  flood_window_counter_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .channel      (channel),
    .member       (member),
    .stat_kind    (stat_kind),
    .now_seconds  (now_seconds),
    .period_value (period_value),
    .limit_value  (limit_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind_out     (kind_out),
    .flood        (flood),
    .limit_out    (limit_out),
    .period_out   (period_out),
    .elapsed      (elapsed),
    .last         (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at result %0d: %s got %0h want %0h", n_results, what, got, want);
    n_fail++;
  endtask

  // Charge one event against its window and queue the expected result
  function automatic void charge_window(input logic [3:0] ch, input logic [3:0] kd,
                                        input logic [31:0] now, input logic is_last);
    int            slot;
    logic [15:0]   per;
    logic [15:0]   lim;
    logic [31:0]   diff;
    rate_verdict_t v;
    slot = ch * N_KIND + kd;
    v = '0;
    v.kind = kd;
    v.last = is_last;
    per = (chan_period[slot] < 0) ? dflt_period[kd] : chan_period[slot][15:0];
    if (per != 16'd0) begin
      lim = (chan_limit[slot] < 0) ? dflt_limit[kd] : chan_limit[slot][15:0];
      diff = now - win_start[slot];
      // restart a window that has run out
      if (diff > {16'd0, per}) begin
        win_start[slot] = now;
        win_count[slot] = '0;
        diff = '0;
      end
      win_count[slot] = win_count[slot] + 17'd1;
      // flood: flag it and restart the window
      if (win_count[slot] > {1'b0, lim}) begin
        v.flood = 1'b1;
        win_start[slot] = now;
        win_count[slot] = '0;
      end
      v.limit = lim;
      v.period = per;
      v.elapsed = diff;
    end
    verdict_q.push_back(v);
  endfunction

  // Apply one accepted item to the predictor
  function automatic void predict_flood_item(input flood_item_t it);
    int                 slot;
    int                 stamp_idx;
    logic signed [16:0] pv;
    logic signed [16:0] lv;
    logic [31:0]        since_join;
    logic               cycled;
    pv = $signed(it.period);
    lv = $signed(it.limit);
    slot = it.channel * N_KIND + it.kind;
    stamp_idx = it.channel * N_MEMB + it.member;
    if (it.kind >= N_KIND) return;
    if (it.opcode == fwc_pkg::OP_DFLT) begin
      dflt_period[it.kind] = (pv < 0) ? 16'd0 : pv[15:0];
      dflt_limit[it.kind]  = (lv < 0) ? 16'd0 : lv[15:0];
      return;
    end
    if (it.opcode == fwc_pkg::OP_CHAN) begin
      if (pv != chan_period[slot]) begin
        chan_period[slot] = pv;
        win_count[slot] = '0;
      end
      chan_limit[slot] = lv;
      return;
    end
    if (it.opcode != fwc_pkg::OP_EVENT) return;
    since_join = it.now - join_stamp[stamp_idx];
    cycled = (it.kind == fwc_pkg::KIND_LEAVE) && (since_join < {16'd0, cycle_win});
    charge_window(it.channel, it.kind, it.now, !cycled);
    if (cycled) charge_window(it.channel, fwc_pkg::KIND_CYCLE, it.now, 1'b1);
    if (it.kind == fwc_pkg::KIND_JOIN) join_stamp[stamp_idx] = it.now;
  endfunction

  function automatic void post_item(input logic [1:0] op, input logic [3:0] ch,
                                    input logic [5:0] mem, input logic [3:0] kd,
                                    input logic [31:0] now, input logic [16:0] pv,
                                    input logic [16:0] lv);
    flood_item_t it;
    it.opcode = op;
    it.channel = ch;
    it.member = mem;
    it.kind = kd;
    it.now = now;
    it.period = pv;
    it.limit = lv;
    pend_items.push_back(it);
    n_queued++;
  endfunction

  function automatic logic [3:0] pick_kind();
    case ($urandom_range(3))
      0: return fwc_pkg::KIND_JOIN;
      1: return fwc_pkg::KIND_LEAVE;
      2: return ($urandom_range(2) == 0) ? fwc_pkg::KIND_CYCLE : fwc_pkg::KIND_LEAVE;
      default: return 4'($urandom_range(N_KIND - 1));
    endcase
  endfunction

  function automatic logic [16:0] pick_period();
    int r;
    r = $urandom_range(19);
    if (r < 12) return 17'($urandom_range(20, 1));
    if (r < 14) return 17'h1FFFF;
    if (r == 14) return 17'd0;
    if (r == 15) return 17'd65535;
    if (r == 16) return 17'($urandom_range(65535));
    return 17'($urandom_range(17'h1FFFF));
  endfunction

  function automatic logic [16:0] pick_limit();
    int r;
    r = $urandom_range(19);
    if (r < 12) return 17'($urandom_range(4));
    if (r < 14) return 17'h1FFFF;
    if (r == 14) return 17'd65535;
    return 17'($urandom_range(17'h1FFFF));
  endfunction

  // Mostly events on a few channels and members with a slowly advancing
  // clock, plus policy updates and some items the block must drop
  function automatic void post_random_item();
    int          sel;
    logic [3:0]  ch;
    logic [5:0]  mem;
    logic [31:0] rnd_pv;
    logic [31:0] rnd_lv;
    sel = $urandom_range(99);
    ch = 4'($urandom_range(15));
    if ($urandom_range(3) != 0) ch = 4'(ch % 3);
    mem = 6'($urandom_range(63));
    if ($urandom_range(3) != 0) mem = 6'(mem % 4);
    if ($urandom_range(49) == 0) time_cursor = $urandom;
    else time_cursor = time_cursor + $urandom_range(8);
    rnd_pv = $urandom;
    rnd_lv = $urandom;
    if (sel < 72)
      post_item(fwc_pkg::OP_EVENT, ch, mem, pick_kind(), time_cursor,
                rnd_pv[16:0], rnd_lv[16:0]);
    else if (sel < 86)
      post_item(fwc_pkg::OP_CHAN, ch, mem, pick_kind(), $urandom, pick_period(),
                pick_limit());
    else if (sel < 94)
      post_item(fwc_pkg::OP_DFLT, ch, mem, pick_kind(), $urandom, pick_period(),
                pick_limit());
    else if (sel < 97)
      post_item(OP_UNUSED, ch, mem, pick_kind(), time_cursor, rnd_pv[16:0], rnd_lv[16:0]);
    else
      post_item(2'($urandom_range(3)), ch, mem, 4'($urandom_range(15, N_KIND)),
                time_cursor, rnd_pv[16:0], rnd_lv[16:0]);
  endfunction

  // Write the register and set idle rates while nothing is in flight
  task automatic start_phase(input logic [15:0] cw, input int s_idle, input int r_idle);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= cw;
    send_idle_pct <= s_idle;
    recv_idle_pct <= r_idle;
    cycle_win = cw;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every item is taken and every result has come
  task automatic drain();
    while (n_accepted != n_queued || verdict_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_flood_item(drv_item);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pend_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = pend_items.pop_front();
          opcode <= drv_item.opcode;
          channel <= drv_item.channel;
          member <= drv_item.member;
          stat_kind <= drv_item.kind;
          now_seconds <= drv_item.now;
          period_value <= drv_item.period;
          limit_value <= drv_item.limit;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (rx_hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : result_check
    rate_verdict_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(kind_out), '0);
      end else begin
        want = verdict_q.pop_front();
        if (kind_out != want.kind)
          report_mismatch("kind_out", 32'(kind_out), 32'(want.kind));
        if (flood != want.flood)
          report_mismatch("flood", 32'(flood), 32'(want.flood));
        if (limit_out != want.limit)
          report_mismatch("limit_out", 32'(limit_out), 32'(want.limit));
        if (period_out != want.period)
          report_mismatch("period_out", 32'(period_out), 32'(want.period));
        if (elapsed != want.elapsed)
          report_mismatch("elapsed", elapsed, want.elapsed);
        if (last != want.last)
          report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < N_CHAN * N_KIND; i++) begin
      chan_period[i] = 17'h1FFFF;
      chan_limit[i] = 17'h1FFFF;
      win_count[i] = '0;
      win_start[i] = '0;
    end
    for (int i = 0; i < N_KIND; i++) begin
      dflt_period[i] = '0;
      dflt_limit[i] = '0;
    end
    for (int i = 0; i < N_CHAN * N_MEMB; i++) join_stamp[i] = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: defaults, floods, window restarts, cycles, wrap, dropped items
    start_phase(16'd20, 35, 60);
    post_item(fwc_pkg::OP_EVENT, 4'd0, 6'd0, 4'd5, 32'd50, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_DFLT, 4'd0, 6'd0, fwc_pkg::KIND_JOIN, 32'd0, 17'd10, 17'd1);
    post_item(fwc_pkg::OP_DFLT, 4'd0, 6'd0, fwc_pkg::KIND_CYCLE, 32'd0, 17'd100, 17'd0);
    post_item(fwc_pkg::OP_DFLT, 4'd0, 6'd0, fwc_pkg::KIND_LEAVE, 32'd0, 17'd65535,
              17'd65535);
    post_item(fwc_pkg::OP_DFLT, 4'd0, 6'd0, 4'd13, 32'd0, 17'h1FFFF, 17'h1FFFB);
    post_item(fwc_pkg::OP_DFLT, 4'd0, 6'd0, 4'd7, 32'd0, 17'd5, 17'd2);
    post_item(fwc_pkg::OP_EVENT, 4'd15, 6'd63, fwc_pkg::KIND_JOIN, 32'd100, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_EVENT, 4'd15, 6'd63, fwc_pkg::KIND_JOIN, 32'd105, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_EVENT, 4'd15, 6'd63, fwc_pkg::KIND_LEAVE, 32'd110, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_EVENT, 4'd15, 6'd63, fwc_pkg::KIND_LEAVE, 32'd125, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_EVENT, 4'd3, 6'd0, fwc_pkg::KIND_LEAVE, 32'd5, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_EVENT, 4'd0, 6'd0, 4'd7, 32'd0, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_EVENT, 4'd0, 6'd0, 4'd7, 32'd6, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_CHAN, 4'd0, 6'd0, 4'd7, 32'd0, 17'd65535, 17'd65535);
    post_item(fwc_pkg::OP_EVENT, 4'd0, 6'd0, 4'd7, 32'hFFFF_FFF0, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_EVENT, 4'd0, 6'd0, 4'd7, 32'h0000_0005, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_CHAN, 4'd0, 6'd0, 4'd7, 32'd0, 17'd0, 17'd3);
    post_item(fwc_pkg::OP_EVENT, 4'd0, 6'd0, 4'd7, 32'd9, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_CHAN, 4'd0, 6'd0, 4'd7, 32'd0, 17'h10000, 17'd0);
    post_item(fwc_pkg::OP_EVENT, 4'd0, 6'd0, 4'd7, 32'd12, 17'd0, 17'd0);
    post_item(fwc_pkg::OP_CHAN, 4'd0, 6'd0, 4'd7, 32'd0, 17'h10000, 17'd65535);
    post_item(fwc_pkg::OP_EVENT, 4'd0, 6'd0, 4'd7, 32'd14, 17'd0, 17'd0);
    post_item(OP_UNUSED, 4'd1, 6'd1, fwc_pkg::KIND_JOIN, 32'd20, 17'd1, 17'd1);
    post_item(fwc_pkg::OP_EVENT, 4'd1, 6'd1, 4'd14, 32'd20, 17'd1, 17'd1);
    post_item(fwc_pkg::OP_DFLT, 4'd1, 6'd1, 4'd15, 32'd20, 17'd1, 17'd1);
    post_item(fwc_pkg::OP_EVENT, 4'd7, 6'd32, 4'd13, 32'hFFFF_FFFF, 17'h1FFFF, 17'h1FFFF);
    drain();

    start_phase(16'hFFFF, 35, 60);
    repeat (250) post_random_item();
    drain();

    start_phase(16'd0, 60, 35);
    repeat (250) post_random_item();
    drain();

    // Receiver holds off while the sender keeps pushing
    start_phase(16'($urandom_range(65535)), 0, 0);
    repeat (60) post_random_item();
    @(posedge clk);
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
    drain();

    start_phase(16'd40, 0, 0);
    repeat (200) post_random_item();
    drain();

    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch("results never produced", '0, 32'(verdict_q.size()));
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/fwc_pkg.sv
sv/fwc_ram.sv
sv/fwc_window.sv
sv/flood_window_counter_unit.sv
bench/tb_flood_window_counter_unit.sv
